// File: hw/rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants of the TCP connection tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd1;

  localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 64'd60000000000;

  typedef enum logic [2:0] {
    CS_NONE        = 3'd0,
    CS_SYN_SENT    = 3'd1,
    CS_SYN_RECV    = 3'd2,
    CS_ESTABLISHED = 3'd3,
    CS_FIN_WAIT1   = 3'd4,
    CS_FIN_WAIT2   = 3'd5,
    CS_TIME_WAIT   = 3'd6
  } conn_state_t;

  typedef struct packed {
    logic                  valid;
    logic [2*ADDR_W-1:0]   addr_pair;
    logic [2*PORT_W-1:0]   port_pair;
    logic [2:0]            conn_state;
    logic [TIME_W-1:0]     seen_time;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic age;
    logic decide;
    logic write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic track_en;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/tct_ctrl.sv
// ----------------------------------------------------------------------------
// tct_ctrl
// Sequencer: table clear after reset, key scan, aging, decision, write-back.
// ----------------------------------------------------------------------------
module tct_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tct_pkg::sts_t  sts,
  output tct_pkg::cmd_t  cmd
);
  import tct_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_AGE, S_DECIDE, S_WRITE, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.track_en ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_AGE;
      end
      S_AGE: begin
        cmd.age   = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/tct_dp.sv
// ----------------------------------------------------------------------------
// tct_dp
// Datapath: key forming, entry table, scan compare, state rules, result reg.
// ----------------------------------------------------------------------------
module tct_dp #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tct_pkg::cmd_t                 cmd,
  output tct_pkg::sts_t                 sts,
  input  logic                          track_en,
  input  logic [tct_pkg::TIME_W-1:0]    idle_timeout,
  input  logic [tct_pkg::ADDR_W-1:0]    in_src_addr,
  input  logic [tct_pkg::ADDR_W-1:0]    in_dst_addr,
  input  logic [tct_pkg::PORT_W-1:0]    in_src_port,
  input  logic [tct_pkg::PORT_W-1:0]    in_dst_port,
  input  logic                          in_flag_syn,
  input  logic                          in_flag_ack,
  input  logic                          in_flag_fin,
  input  logic                          in_flag_rst,
  input  logic                          in_flag_psh,
  input  logic [tct_pkg::TIME_W-1:0]    in_arrival_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_drop,
  output logic [2:0]                    out_conn_state_after,
  output logic                          out_insert_failed
);
  import tct_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata_r;

  logic [2*ADDR_W-1:0] akey_r;
  logic [2*PORT_W-1:0] pkey_r;
  logic syn_r, ack_r, fin_r, rst_r, psh_r;
  logic [TIME_W-1:0] now_r;

  logic [CNT_W-1:0] cnt_r;
  logic             chk_v_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             hit_r, free_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r;
  logic [2:0]       hit_state_r;
  logic [TIME_W-1:0] hit_last_r, age_r;

  logic             wr_en_r, wr_en_nxt;
  logic [IDX_W-1:0] wr_addr_r, wr_addr_nxt;
  entry_t           wr_data_r, wr_data_nxt;
  logic             res_drop_r, res_drop_nxt;
  logic [2:0]       res_st_r, res_st_nxt;
  logic             res_fail_r, res_fail_nxt;

  logic             out_valid_r;
  logic             out_drop_r, out_fail_r;
  logic [2:0]       out_st_r;

  logic             issue;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;
  logic             match;
  logic [2:0]       nst;
  logic             del, rej;

  assign issue = cmd.scan && (cnt_r < CNT_W'(TABLE_ENTRIES));
  assign match = rdata_r.valid && (rdata_r.addr_pair == akey_r)
                 && (rdata_r.port_pair == pkey_r);

  assign sts.clr_done  = (cnt_r[IDX_W-1:0] == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.scan_done = chk_v_r && (chk_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.track_en  = track_en;
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    we = 1'b0;
    wa = wr_addr_r;
    wd = wr_data_r;
    if (cmd.clr) begin
      we = 1'b1;
      wa = cnt_r[IDX_W-1:0];
      wd = '0;
    end else if (cmd.write && wr_en_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata_r <= mem[cnt_r[IDX_W-1:0]];
  end

  // state rules for a live hit
  always_comb begin
    nst = hit_state_r;
    del = 1'b0;
    rej = 1'b0;
    case (hit_state_r)
      CS_SYN_SENT: begin
        if (!syn_r && ack_r) nst = CS_ESTABLISHED;
        else if (syn_r && ack_r) nst = CS_SYN_RECV;
        else if (rst_r) del = 1'b1;
        else rej = 1'b1;
      end
      CS_SYN_RECV: begin
        if (ack_r && !syn_r) nst = CS_ESTABLISHED;
        else rej = 1'b1;
      end
      CS_ESTABLISHED: begin
        if (fin_r) nst = CS_FIN_WAIT1;
        else if (rst_r) del = 1'b1;
        else if (!ack_r) rej = 1'b1;
      end
      CS_FIN_WAIT1: begin
        if (ack_r) nst = CS_FIN_WAIT2;
        else rej = 1'b1;
      end
      CS_FIN_WAIT2: begin
        if (fin_r) nst = CS_TIME_WAIT;
        else if (!(ack_r || psh_r)) rej = 1'b1;
      end
      CS_TIME_WAIT: begin
        if (ack_r) del = 1'b1;
        else rej = 1'b1;
      end
      default: rej = 1'b1;
    endcase
  end

  always_comb begin
    wr_en_nxt    = 1'b0;
    wr_addr_nxt  = hit_idx_r;
    wr_data_nxt  = '{valid: 1'b0, addr_pair: akey_r, port_pair: pkey_r,
                     conn_state: hit_state_r, seen_time: hit_last_r};
    res_drop_nxt = 1'b0;
    res_st_nxt   = CS_NONE;
    res_fail_nxt = 1'b0;
    if (!track_en) begin
      res_drop_nxt = 1'b0;
    end else if (!hit_r) begin
      if (syn_r && !ack_r) begin
        if (!free_r) begin
          res_fail_nxt = 1'b1;
        end else begin
          wr_en_nxt   = 1'b1;
          wr_addr_nxt = free_idx_r;
          wr_data_nxt = '{valid: 1'b1, addr_pair: akey_r, port_pair: pkey_r,
                          conn_state: CS_SYN_RECV, seen_time: now_r};
          res_st_nxt  = CS_SYN_RECV;
        end
      end else begin
        res_drop_nxt = 1'b1;
      end
    end else if (age_r > idle_timeout) begin
      wr_en_nxt    = 1'b1;
      res_drop_nxt = 1'b1;
    end else if (rej) begin
      res_drop_nxt = 1'b1;
      res_st_nxt   = hit_state_r;
    end else if (del) begin
      wr_en_nxt    = 1'b1;
      res_drop_nxt = (hit_state_r == CS_ESTABLISHED);
    end else begin
      wr_en_nxt   = 1'b1;
      wr_data_nxt = '{valid: 1'b1, addr_pair: akey_r, port_pair: pkey_r,
                      conn_state: nst, seen_time: now_r};
      res_st_nxt  = nst;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      akey_r <= (in_src_addr > in_dst_addr) ? {in_src_addr, in_dst_addr}
                                            : {in_dst_addr, in_src_addr};
      pkey_r <= (in_src_port > in_dst_port) ? {in_src_port, in_dst_port}
                                            : {in_dst_port, in_src_port};
      syn_r  <= in_flag_syn;
      ack_r  <= in_flag_ack;
      fin_r  <= in_flag_fin;
      rst_r  <= in_flag_rst;
      psh_r  <= in_flag_psh;
      now_r  <= in_arrival_time;
    end
    chk_idx_r <= cnt_r[IDX_W-1:0];
    if (chk_v_r && match && !hit_r) begin
      hit_idx_r   <= chk_idx_r;
      hit_state_r <= rdata_r.conn_state;
      hit_last_r  <= rdata_r.seen_time;
    end
    if (chk_v_r && !rdata_r.valid && !free_r) free_idx_r <= chk_idx_r;
    if (cmd.age) age_r <= now_r - hit_last_r;
    if (cmd.decide) begin
      wr_addr_r  <= wr_addr_nxt;
      wr_data_r  <= wr_data_nxt;
      res_drop_r <= res_drop_nxt;
      res_st_r   <= res_st_nxt;
      res_fail_r <= res_fail_nxt;
    end
    if (cmd.emit) begin
      out_drop_r <= res_drop_r;
      out_st_r   <= res_st_r;
      out_fail_r <= res_fail_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r   <= '0;
        chk_v_r <= 1'b0;
        hit_r   <= 1'b0;
        free_r  <= 1'b0;
      end else begin
        if (cmd.clr || issue) cnt_r <= cnt_r + CNT_W'(1);
        chk_v_r <= issue;
        if (chk_v_r && match) hit_r <= 1'b1;
        if (chk_v_r && !rdata_r.valid) free_r <= 1'b1;
      end
      if (cmd.decide) wr_en_r <= wr_en_nxt;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drop             = out_drop_r;
  assign out_conn_state_after = out_st_r;
  assign out_insert_failed    = out_fail_r;

endmodule

// File: hw/rtl/tcp_connection_tracker_unit.sv
// ----------------------------------------------------------------------------
// tcp_connection_tracker_unit
// Stateful TCP connection tracking table with a per-packet drop verdict.
// ----------------------------------------------------------------------------
// One packet is processed at a time. With tracking enabled every entry of
// the table memory is read once through its single registered read port,
// then the entry ages, the state rules decide and the write-back follows.
// With tracking disabled the packet goes straight to the decision. After
// reset the block clears the table, one entry per cycle, and holds in_stall
// high meanwhile; configuration writes are taken at any time.
module tcp_connection_tracker_unit #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tct_pkg::ADDR_W-1:0]        in_src_addr,
  input  logic [tct_pkg::ADDR_W-1:0]        in_dst_addr,
  input  logic [tct_pkg::PORT_W-1:0]        in_src_port,
  input  logic [tct_pkg::PORT_W-1:0]        in_dst_port,
  input  logic                              in_flag_syn,
  input  logic                              in_flag_ack,
  input  logic                              in_flag_fin,
  input  logic                              in_flag_rst,
  input  logic                              in_flag_psh,
  input  logic [tct_pkg::TIME_W-1:0]        in_arrival_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_drop,
  output logic [2:0]                        out_conn_state_after,
  output logic                              out_insert_failed
);
  import tct_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic              track_en_r;
  logic [TIME_W-1:0] idle_timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_en_r     <= 1'b0;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRACK_EN:     track_en_r     <= cfg_wdata[0];
        REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tct_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .track_en             (track_en_r),
    .idle_timeout         (idle_timeout_r),
    .in_src_addr          (in_src_addr),
    .in_dst_addr          (in_dst_addr),
    .in_src_port          (in_src_port),
    .in_dst_port          (in_dst_port),
    .in_flag_syn          (in_flag_syn),
    .in_flag_ack          (in_flag_ack),
    .in_flag_fin          (in_flag_fin),
    .in_flag_rst          (in_flag_rst),
    .in_flag_psh          (in_flag_psh),
    .in_arrival_time      (in_arrival_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_drop             (out_drop),
    .out_conn_state_after (out_conn_state_after),
    .out_insert_failed    (out_insert_failed)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a packet is in progress");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during table clear");

  a_fail_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_insert_failed |-> !out_drop && out_conn_state_after == CS_NONE)
    else $error("failed insert must pass with no state");

  a_drop_not_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drop |-> out_conn_state_after != CS_SYN_RECV || !out_insert_failed)
    else $error("dropped packet reports insert failure");

endmodule

// File: tb/tcp_connection_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// tcp_connection_tracker_unit_tb
// Self-checking bench for the TCP connection tracker. A packet queue feeds a
// clocked driver; every transfer updates a local copy of the connection table
// and queues the expected verdict, which the monitor checks field by field.
// Stimulus covers tracking on and off, full TCP sessions seen from both
// directions, broken sessions, idle timeouts and a completely filled table.
// ----------------------------------------------------------------------------
module tcp_connection_tracker_unit_tb;
  import tct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = 256;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  localparam bit [4:0] FL_SYN = 5'b00001;
  localparam bit [4:0] FL_ACK = 5'b00010;
  localparam bit [4:0] FL_FIN = 5'b00100;
  localparam bit [4:0] FL_RST = 5'b01000;
  localparam bit [4:0] FL_PSH = 5'b10000;

  typedef struct {
    bit [ADDR_W-1:0] sa;
    bit [ADDR_W-1:0] da;
    bit [PORT_W-1:0] sp;
    bit [PORT_W-1:0] dp;
    bit [4:0]        flags;
    bit [TIME_W-1:0] ts;
  } packet_t;

  typedef struct {
    bit          drop;
    conn_state_t st;
    bit          fail;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ADDR_W-1:0] in_src_addr = '0;
  logic [ADDR_W-1:0] in_dst_addr = '0;
  logic [PORT_W-1:0] in_src_port = '0;
  logic [PORT_W-1:0] in_dst_port = '0;
  logic in_flag_syn = 1'b0;
  logic in_flag_ack = 1'b0;
  logic in_flag_fin = 1'b0;
  logic in_flag_rst = 1'b0;
  logic in_flag_psh = 1'b0;
  logic [TIME_W-1:0] in_arrival_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_drop;
  logic [2:0] out_conn_state_after;
  logic out_insert_failed;

  tcp_connection_tracker_unit #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

  always #5 clk = ~clk;

  // local copy of configuration and table
  bit              track_en;
  bit [TIME_W-1:0] idle_to;
  bit              tbl_valid [ENTRIES];
  bit [63:0]       tbl_addr [ENTRIES];
  bit [31:0]       tbl_port [ENTRIES];
  conn_state_t     tbl_state [ENTRIES];
  bit [TIME_W-1:0] tbl_seen [ENTRIES];

  packet_t  pkt_q[$];
  verdict_t verdicts[$];
  packet_t  cur_pkt;
  int       send_idle_pct;
  int       stall_pct;
  int       errors;
  longint unsigned cycles;
  bit [TIME_W-1:0] now_ts;

  bit [ADDR_W-1:0] pool_a [16];
  bit [ADDR_W-1:0] pool_b [16];
  bit [PORT_W-1:0] pool_pa [16];
  bit [PORT_W-1:0] pool_pb [16];

  function automatic verdict_t track_packet(packet_t p);
    verdict_t    v;
    bit [31:0]   ahi, alo;
    bit [15:0]   phi, plo;
    bit [63:0]   akey;
    bit [31:0]   pkey;
    int          hit;
    int          free_slot;
    bit          syn, ack, fin, rst, psh;
    conn_state_t st;
    bit          reject;
    v = '{1'b0, CS_NONE, 1'b0};
    if (!track_en) return v;
    {psh, rst, fin, ack, syn} = p.flags;
    ahi = (p.sa > p.da) ? p.sa : p.da;
    alo = (p.sa > p.da) ? p.da : p.sa;
    phi = (p.sp > p.dp) ? p.sp : p.dp;
    plo = (p.sp > p.dp) ? p.dp : p.sp;
    akey = {ahi, alo};
    pkey = {phi, plo};
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_addr[i] == akey && tbl_port[i] == pkey) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (syn && !ack) begin
        if (free_slot < 0) begin
          v.fail = 1'b1;
          return v;
        end
        tbl_valid[free_slot] = 1'b1;
        tbl_addr[free_slot] = akey;
        tbl_port[free_slot] = pkey;
        tbl_state[free_slot] = CS_SYN_RECV;
        tbl_seen[free_slot] = p.ts;
        v.st = CS_SYN_RECV;
        return v;
      end
      v.drop = 1'b1;
      return v;
    end
    if (p.ts - tbl_seen[hit] > idle_to) begin
      tbl_valid[hit] = 1'b0;
      v.drop = 1'b1;
      return v;
    end
    st = tbl_state[hit];
    reject = 1'b0;
    case (st)
      CS_SYN_SENT: begin
        if (!syn && ack) st = CS_ESTABLISHED;
        else if (syn && ack) st = CS_SYN_RECV;
        else if (rst) begin
          tbl_valid[hit] = 1'b0;
          return v;
        end else reject = 1'b1;
      end
      CS_SYN_RECV: begin
        if (ack && !syn) st = CS_ESTABLISHED;
        else reject = 1'b1;
      end
      CS_ESTABLISHED: begin
        if (fin) st = CS_FIN_WAIT1;
        else if (rst) begin
          tbl_valid[hit] = 1'b0;
          v.drop = 1'b1;
          return v;
        end else if (!ack) reject = 1'b1;
      end
      CS_FIN_WAIT1: begin
        if (ack) st = CS_FIN_WAIT2;
        else reject = 1'b1;
      end
      CS_FIN_WAIT2: begin
        if (fin) st = CS_TIME_WAIT;
        else if (!(ack || psh)) reject = 1'b1;
      end
      CS_TIME_WAIT: begin
        if (ack) begin
          tbl_valid[hit] = 1'b0;
          return v;
        end
        reject = 1'b1;
      end
      default: reject = 1'b1;
    endcase
    if (reject) begin
      v.drop = 1'b1;
      v.st = tbl_state[hit];
      return v;
    end
    tbl_state[hit] = st;
    tbl_seen[hit] = p.ts;
    v.st = st;
    return v;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tcp_connection_tracker_unit verification failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) verdicts.push_back(track_packet(cur_pkt));
      if (pkt_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_pkt = pkt_q.pop_front();
        in_valid <= 1'b1;
        in_src_addr <= cur_pkt.sa;
        in_dst_addr <= cur_pkt.da;
        in_src_port <= cur_pkt.sp;
        in_dst_port <= cur_pkt.dp;
        {in_flag_psh, in_flag_rst, in_flag_fin, in_flag_ack, in_flag_syn} <= cur_pkt.flags;
        in_arrival_time <= cur_pkt.ts;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result drop=%0b st=%0d fail=%0b",
                                   out_drop, out_conn_state_after, out_insert_failed);
      end else begin
        e = verdicts.pop_front();
        if (out_drop !== e.drop || out_conn_state_after !== e.st ||
            out_insert_failed !== e.fail) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp drop=%0b st=%0d fail=%0b, got drop=%0b st=%0d fail=%0b",
                     e.drop, e.st, e.fail, out_drop, out_conn_state_after,
                     out_insert_failed);
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic drain();
    while (pkt_q.size() != 0 || in_valid || verdicts.size() != 0) @(negedge clk);
    repeat (ENTRIES + 16) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TRACK_EN) track_en = val[0];
    else idle_to = val;
  endtask

  task automatic send(input bit [31:0] a, b, input bit [15:0] pa, pb,
                      input bit [4:0] fl, input bit [63:0] dt);
    packet_t p;
    now_ts += dt;
    p = '{a, b, pa, pb, fl, now_ts};
    pkt_q.push_back(p);
  endtask

  task automatic send_key(input int k, input bit [4:0] fl, input bit [63:0] dt);
    if ($urandom_range(1)) send(pool_a[k], pool_b[k], pool_pa[k], pool_pb[k], fl, dt);
    else send(pool_b[k], pool_a[k], pool_pb[k], pool_pa[k], fl, dt);
  endtask

  function automatic bit [63:0] step_time();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 64'd12000 + 64'($urandom_range(5000));
    if (r < 20) return 64'd0;
    return 64'($urandom_range(3000));
  endfunction

  function automatic bit [4:0] mangle(input bit [4:0] fl);
    if ($urandom_range(99) < 12) return 5'($urandom);
    return fl;
  endfunction

  task automatic session(input int k);
    int n;
    send_key(k, mangle(FL_SYN), step_time());
    if ($urandom_range(3) == 0) send_key(k, FL_SYN | FL_ACK, step_time());
    send_key(k, mangle(FL_ACK), step_time());
    n = $urandom_range(3);
    repeat (n) send_key(k, mangle($urandom_range(1) ? FL_ACK : FL_ACK | FL_PSH), step_time());
    if ($urandom_range(5) == 0) send_key(k, FL_RST, step_time());
    send_key(k, mangle($urandom_range(1) ? FL_FIN : FL_FIN | FL_ACK), step_time());
    send_key(k, mangle(FL_ACK), step_time());
    if ($urandom_range(1)) send_key(k, mangle(FL_PSH), step_time());
    send_key(k, mangle(FL_FIN), step_time());
    send_key(k, mangle(FL_ACK), step_time());
  endtask

  task automatic random_phase(input int sessions);
    for (int i = 0; i < 16; i++) begin
      pool_a[i] = $urandom;
      pool_b[i] = (i % 4 == 0) ? pool_a[i] : $urandom;
      pool_pa[i] = 16'($urandom);
      pool_pb[i] = (i % 5 == 0) ? pool_pa[i] : 16'($urandom);
    end
    now_ts = {$urandom, $urandom};
    for (int s = 0; s < sessions; s++) begin
      session($urandom_range(15));
      if ($urandom_range(3) == 0)
        send($urandom, $urandom, 16'($urandom), 16'($urandom), 5'($urandom), step_time());
      if (s == sessions / 2) drain();
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_port[i] = '0;
      tbl_state[i] = CS_NONE;
      tbl_seen[i] = '0;
    end
    track_en = 1'b0;
    idle_to = IDLE_TIMEOUT_RST;
    send_idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    cycles = 0;
    now_ts = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // tracking off, reset configuration
    send('1, '0, '1, '0, FL_SYN, 0);
    send('0, '1, '0, '1, 5'b11111, 5);
    send(32'h0a000001, 32'h0a000002, 16'd80, 16'd443, FL_ACK, 7);
    drain();

    cfg_write(REG_TRACK_EN, 64'd1);
    cfg_write(REG_IDLE_TIMEOUT, '1);
    now_ts = 64'hffff_ffff_ffff_fff0;
    send('1, '0, '1, '0, FL_ACK, 1);
    send('1, '0, '1, '0, FL_SYN | FL_ACK, 1);
    send('1, '0, '1, '0, FL_SYN, 1);
    send('0, '1, '0, '1, FL_SYN, 1);
    send('0, '1, '0, '1, FL_PSH, 1);
    send('0, '1, '0, '1, FL_ACK, 1);
    send('1, '0, '1, '0, FL_PSH, 1);
    send('0, '1, '0, '1, FL_ACK | FL_PSH, 1);
    send('1, '0, '1, '0, FL_FIN, 1);
    send('0, '1, '0, '1, FL_SYN, 1);
    send('1, '0, '1, '0, FL_ACK, 1);
    send('1, '0, '1, '0, FL_PSH, 1);
    send('0, '1, '0, '1, FL_RST, 1);
    send('1, '0, '1, '0, FL_FIN, 1);
    send('1, '0, '1, '0, FL_PSH, 1);
    send('0, '1, '0, '1, FL_ACK, 1);
    send(32'd5, 32'd5, 16'd9, 16'd9, FL_SYN, 1);
    send(32'd5, 32'd5, 16'd9, 16'd9, FL_ACK, 1);
    send(32'd5, 32'd5, 16'd9, 16'd9, FL_RST, 1);
    send(32'd5, 32'd5, 16'd9, 16'd9, FL_ACK, 1);
    drain();

    send_idle_pct = 35;
    stall_pct = 83;
    cfg_write(REG_IDLE_TIMEOUT, 64'd5000);
    random_phase(22);
    drain();

    send_idle_pct = 83;
    stall_pct = 35;
    cfg_write(REG_IDLE_TIMEOUT, 64'd0);
    random_phase(8);
    drain();
    cfg_write(REG_IDLE_TIMEOUT, 64'd9000);
    random_phase(16);
    drain();

    send_idle_pct = 0;
    stall_pct = 0;
    cfg_write(REG_TRACK_EN, 64'd0);
    random_phase(2);
    drain();
    cfg_write(REG_TRACK_EN, 64'd1);
    cfg_write(REG_IDLE_TIMEOUT, '1);
    for (int i = 0; i < ENTRIES + 8; i++)
      send(32'hc0a80000 + i, 32'h0a000000, 16'(i), 16'd22, FL_SYN, 1);
    send(32'h0a000000, 32'hc0a80003, 16'd22, 16'd3, FL_ACK, 1);
    drain();

    if (errors == 0 && verdicts.size() == 0) begin
      $display("tcp_connection_tracker_unit verification clean");
    end else begin
      $display("tcp_connection_tracker_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tct_pkg.sv
hw/rtl/tct_ctrl.sv
hw/rtl/tct_dp.sv
hw/rtl/tcp_connection_tracker_unit.sv
tb/tcp_connection_tracker_unit_tb.sv
